// ===== sv/hsv2rgb_pkg.sv =====
`default_nettype none

package hsv2rgb_pkg;

    // Fraction format of saturation and value: 1 << FRACTION_BITS means 1.0
    localparam int FRACTION_BITS = 12;
    localparam int ONE = 1 << FRACTION_BITS;

    // Port widths
    localparam int IN_W = 13;
    localparam int CH_W = 8;

    // Clamped fraction, 0..ONE
    localparam int VAL_W = FRACTION_BITS + 1;
    localparam int CMP_W = (IN_W > VAL_W) ? IN_W : VAL_W;

    // Hue geometry in 1/16 degree units
    localparam int HUE_SECTOR_UNITS = 960;
    localparam int HUE_FULL_UNITS = 6 * HUE_SECTOR_UNITS;
    localparam int CHANNEL_MAX = 255;
    localparam logic [IN_W-1:0] HUE_FULL = IN_W'(HUE_FULL_UNITS);
    localparam logic [IN_W-1:0] HUE_SEC1 = IN_W'(1 * HUE_SECTOR_UNITS);
    localparam logic [IN_W-1:0] HUE_SEC2 = IN_W'(2 * HUE_SECTOR_UNITS);
    localparam logic [IN_W-1:0] HUE_SEC3 = IN_W'(3 * HUE_SECTOR_UNITS);
    localparam logic [IN_W-1:0] HUE_SEC4 = IN_W'(4 * HUE_SECTOR_UNITS);
    localparam logic [IN_W-1:0] HUE_SEC5 = IN_W'(5 * HUE_SECTOR_UNITS);

    // Per-channel weight k: channel = 255*v*(960*ONE - s*k) / (960*ONE*ONE)
    localparam int K_W = $clog2(HUE_SECTOR_UNITS + 1);
    localparam logic [K_W-1:0] K_FULL = '0;
    localparam logic [K_W-1:0] K_ZERO = K_W'(HUE_SECTOR_UNITS);
    localparam logic [K_W-1:0] K_SECTOR = K_W'(HUE_SECTOR_UNITS);

    // Datapath widths
    localparam int W_W = $clog2(HUE_SECTOR_UNITS * ONE + 1);
    localparam logic [W_W-1:0] W_FULL = W_W'(HUE_SECTOR_UNITS * ONE);
    localparam int Q_W = VAL_W + W_W;
    localparam int N_W = Q_W + 8;
    // 960 = 15 * 64: shift out 64*ONE*ONE, then divide by 15
    localparam int SHIFT = 2 * FRACTION_BITS + 6;
    localparam int A_W = $clog2(CHANNEL_MAX * 15 + 1);
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP = ((1 << RECIP_SHIFT) + 14) / 15;
    localparam int RECIP_W = $clog2(RECIP + 1);
    localparam int R_W = A_W + RECIP_W;

    // Hue sector codes
    localparam int SEC_W = 3;
    localparam logic [SEC_W-1:0] SEC_RED_YEL = 3'd0;
    localparam logic [SEC_W-1:0] SEC_YEL_GRN = 3'd1;
    localparam logic [SEC_W-1:0] SEC_GRN_CYN = 3'd2;
    localparam logic [SEC_W-1:0] SEC_CYN_BLU = 3'd3;
    localparam logic [SEC_W-1:0] SEC_BLU_MAG = 3'd4;
    localparam logic [SEC_W-1:0] SEC_MAG_RED = 3'd5;

    // Stage enables handed to each channel datapath
    typedef struct packed {
        logic en3;
        logic en4;
        logic en5;
        logic en6;
    } stage_ctl_t;

    // Saturate a raw fraction to 1.0
    function automatic logic [VAL_W-1:0] clamp_fraction(input logic [IN_W-1:0] raw);
        logic [CMP_W-1:0] ext;
        begin
            ext = CMP_W'(raw);
            if (ext > CMP_W'(ONE))
                clamp_fraction = VAL_W'(ONE);
            else
                clamp_fraction = VAL_W'(ext);
        end
    endfunction

endpackage

`default_nettype wire

// ===== sv/hsv2rgb_channel.sv =====
`default_nettype none

module hsv2rgb_channel import hsv2rgb_pkg::*; (
    input  wire logic             clk,
    input  wire stage_ctl_t       ctl,
    input  wire logic [VAL_W-1:0] sat,
    input  wire logic [VAL_W-1:0] val,
    input  wire logic [K_W-1:0]   weight_k,
    output logic [CH_W-1:0]       level
);

    logic [VAL_W+K_W-1:0] prod;
    logic [W_W-1:0]       w_next;
    logic [W_W-1:0]       w_reg;
    logic [VAL_W-1:0]     val_reg;
    logic [Q_W-1:0]       q_next;
    logic [Q_W-1:0]       q_reg;
    logic [N_W-1:0]       n_full;
    logic [A_W-1:0]       a_next;
    logic [A_W-1:0]       a_reg;
    logic [R_W-1:0]       r_prod;
    logic [R_W-1:0]       r_quo;
    logic [CH_W-1:0]      level_next;
    logic [CH_W-1:0]      level_reg;

    // Stage 3: weight = 960*ONE - s*k
    always_comb
    begin
        prod   = (VAL_W+K_W)'(sat) * (VAL_W+K_W)'(weight_k);
        w_next = W_FULL - W_W'(prod);
    end

    // Stage 4: scale by value
    assign q_next = Q_W'(val_reg) * Q_W'(w_reg);

    // Stage 5: times 255, drop the power-of-two part of the divisor
    always_comb
    begin
        n_full = {q_reg, 8'b0} - N_W'(q_reg);
        a_next = A_W'(n_full >> SHIFT);
    end

    // Stage 6: divide by 15 through a reciprocal, saturate to channel range
    always_comb
    begin
        r_prod = R_W'(a_reg) * R_W'(RECIP);
        r_quo  = r_prod >> RECIP_SHIFT;
        if (r_quo > R_W'(CHANNEL_MAX))
            level_next = CH_W'(CHANNEL_MAX);
        else
            level_next = CH_W'(r_quo);
    end

    // Advance each stage when its enable is set, hold otherwise
    always_ff @(posedge clk)
    begin
        if (ctl.en3)
        begin
            w_reg   <= w_next;
            val_reg <= val;
        end
        if (ctl.en4)
            q_reg <= q_next;
        if (ctl.en5)
            a_reg <= a_next;
        if (ctl.en6)
            level_reg <= level_next;
    end

    assign level = level_reg;

endmodule

`default_nettype wire

// ===== sv/hsv_to_rgb_converter.sv =====
// Channel  Signals                               Direction
// input    in_valid, in_ready, hue,              in (in_ready out)
//          saturation, brightness_level
// output   out_valid, out_ready, red,            out (out_ready in)
//          green, blue
//
// Six register stages: clamp/wrap, sector and hue ramp, channel weight,
// value product, scale by 255, divide by 15. One item is taken every cycle
// while the output is not stalled, since each stage advances unless the one
// after it is full and held, and each stage holds at most one multiply.
// Reset clears only the stage valid bits; the pipeline is empty after reset.
// A stall at the output holds the last stage; empty stages upstream still
// fill, so bubbles close up and no item is lost or repeated.

`default_nettype none

module hsv_to_rgb_converter import hsv2rgb_pkg::*; (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic [IN_W-1:0] hue,
    input  wire logic [IN_W-1:0] saturation,
    input  wire logic [IN_W-1:0] brightness_level,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic [CH_W-1:0]      red,
    output logic [CH_W-1:0]      green,
    output logic [CH_W-1:0]      blue
);

    localparam int STAGES = 6;

    logic [STAGES:1]  vld_reg;
    logic [STAGES:1]  vld_next;
    logic [STAGES+1:1] en;
    stage_ctl_t       ctl;

    logic [IN_W-1:0]  h1_next;
    logic [IN_W-1:0]  h1_reg;
    logic [VAL_W-1:0] s1_reg;
    logic [VAL_W-1:0] v1_reg;

    logic [SEC_W-1:0] sector_next;
    logic [IN_W-1:0]  pos;
    logic [K_W-1:0]   t_next;
    logic [SEC_W-1:0] sector_reg;
    logic [K_W-1:0]   t_reg;
    logic [VAL_W-1:0] s2_reg;
    logic [VAL_W-1:0] v2_reg;

    logic [K_W-1:0]   k_red;
    logic [K_W-1:0]   k_green;
    logic [K_W-1:0]   k_blue;

    // Stage enables: a stage moves when empty or when the next one moves
    always_comb
    begin
        en[STAGES+1] = out_ready;
        for (int i = STAGES; i >= 1; i--)
            en[i] = !vld_reg[i] || en[i+1];
        if (en[1])
            vld_next[1] = in_valid;
        else
            vld_next[1] = vld_reg[1];
        for (int i = 2; i <= STAGES; i++)
        begin
            if (en[i])
                vld_next[i] = vld_reg[i-1];
            else
                vld_next[i] = vld_reg[i];
        end
        ctl.en3 = en[3];
        ctl.en4 = en[4];
        ctl.en5 = en[5];
        ctl.en6 = en[6];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign in_ready  = en[1];
    assign out_valid = vld_reg[STAGES];

    // Stage 1: wrap hue into one turn
    assign h1_next = (hue >= HUE_FULL) ? (hue - HUE_FULL) : hue;

    // Stage 2: sector and distance from the nearest odd sector edge (60, 180 or 300 degrees)
    always_comb
    begin
        if (h1_reg < HUE_SEC1)
            sector_next = SEC_RED_YEL;
        else if (h1_reg < HUE_SEC2)
            sector_next = SEC_YEL_GRN;
        else if (h1_reg < HUE_SEC3)
            sector_next = SEC_GRN_CYN;
        else if (h1_reg < HUE_SEC4)
            sector_next = SEC_CYN_BLU;
        else if (h1_reg < HUE_SEC5)
            sector_next = SEC_BLU_MAG;
        else
            sector_next = SEC_MAG_RED;

        case (sector_next) inside
            SEC_RED_YEL, SEC_YEL_GRN: pos = h1_reg;
            SEC_GRN_CYN, SEC_CYN_BLU: pos = h1_reg - HUE_SEC2;
            default:                  pos = h1_reg - HUE_SEC4;
        endcase

        if (pos >= HUE_SEC1)
            t_next = K_W'(pos - HUE_SEC1);
        else
            t_next = K_W'(HUE_SEC1 - pos);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            h1_reg <= h1_next;
            s1_reg <= clamp_fraction(saturation);
            v1_reg <= clamp_fraction(brightness_level);
        end
        if (en[2])
        begin
            sector_reg <= sector_next;
            t_reg      <= t_next;
            s2_reg     <= s1_reg;
            v2_reg     <= v1_reg;
        end
    end

    // Pick per-channel weight: full chroma, ramp, or none
    always_comb
    begin
        unique case (sector_reg)
            SEC_RED_YEL:
            begin
                k_red = K_FULL;
                k_green = t_reg;
                k_blue = K_ZERO;
            end
            SEC_YEL_GRN:
            begin
                k_red = t_reg;
                k_green = K_FULL;
                k_blue = K_ZERO;
            end
            SEC_GRN_CYN:
            begin
                k_red = K_ZERO;
                k_green = K_FULL;
                k_blue = t_reg;
            end
            SEC_CYN_BLU:
            begin
                k_red = K_ZERO;
                k_green = t_reg;
                k_blue = K_FULL;
            end
            SEC_BLU_MAG:
            begin
                k_red = t_reg;
                k_green = K_ZERO;
                k_blue = K_FULL;
            end
            default:
            begin
                k_red = K_FULL;
                k_green = K_ZERO;
                k_blue = t_reg;
            end
        endcase
    end

    // Stages 3 to 6, one datapath per channel
    hsv2rgb_channel u_red (
        .clk      (clk),
        .ctl      (ctl),
        .sat      (s2_reg),
        .val      (v2_reg),
        .weight_k (k_red),
        .level    (red)
    );

    hsv2rgb_channel u_green (
        .clk      (clk),
        .ctl      (ctl),
        .sat      (s2_reg),
        .val      (v2_reg),
        .weight_k (k_green),
        .level    (green)
    );

    hsv2rgb_channel u_blue (
        .clk      (clk),
        .ctl      (ctl),
        .sat      (s2_reg),
        .val      (v2_reg),
        .weight_k (k_blue),
        .level    (blue)
    );

    // An empty output stage never blocks the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with an empty output stage");

    // A full pipeline under output stall takes no item
    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (&vld_reg && !out_ready) |-> !in_ready)
        else $error("item taken into a full stalled pipeline");

    // Wrapped hue always lands in one of six sectors
    a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[2] |-> (sector_reg <= SEC_MAG_RED))
        else $error("hue sector out of range");

    // Ramp distance never exceeds one sector
    a_ramp_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[2] |-> (t_reg <= K_SECTOR))
        else $error("hue ramp out of range");

endmodule

`default_nettype wire

// ===== tb/sv/tb_hsv_to_rgb_converter.sv =====
`default_nettype none

module tb_hsv_to_rgb_converter;
    import hsv2rgb_pkg::*;

    localparam int PIPE_LATENCY = 6;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RUN_LIMIT = 2000000;
    localparam int PRINT_CAP = 40;

    typedef struct {
        logic [IN_W-1:0] hue;
        logic [IN_W-1:0] sat;
        logic [IN_W-1:0] val;
    } hsv_item_t;

    typedef struct {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rgb_item_t;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            in_valid = 1'b0;
    logic            in_ready;
    logic [IN_W-1:0] hue = '0;
    logic [IN_W-1:0] saturation = '0;
    logic [IN_W-1:0] brightness_level = '0;
    logic            out_valid;
    logic            out_ready = 1'b0;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;

    hsv_item_t pending_colors[$];
    rgb_item_t expected_rgb[$];

    logic in_taken = 1'b0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    bit   hold_off_req = 1'b0;
    int   mismatch_count = 0;
    int   colors_taken = 0;
    int   colors_checked = 0;
    int   stalled_input_cycles = 0;

    hsv_to_rgb_converter dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .hue              (hue),
        .saturation       (saturation),
        .brightness_level (brightness_level),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .red              (red),
        .green            (green),
        .blue             (blue)
    );

    // Free-running clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Scale one channel: floor(p * 255 / denom), saturated at full scale
    function automatic logic [CH_W-1:0] scale_to_byte(input longint unsigned p,
                                                     input longint unsigned denom);
        longint unsigned r;
        begin
            r = (p * CHANNEL_MAX) / denom;
            if (r > CHANNEL_MAX)
                r = CHANNEL_MAX;
            return CH_W'(r);
        end
    endfunction

    // Predict the RGB color for one HSV item with exact integer arithmetic
    function automatic rgb_item_t convert_hsv(input hsv_item_t item);
        longint unsigned one;
        longint unsigned denom;
        longint unsigned h;
        longint unsigned s;
        longint unsigned v;
        longint unsigned pos;
        longint unsigned ramp;
        longint unsigned chroma;
        longint unsigned second;
        longint unsigned offset;
        longint unsigned rp;
        longint unsigned gp;
        longint unsigned bp;
        logic [SEC_W-1:0] sector;
        rgb_item_t rgb;
        begin
            one = longint'(ONE);
            denom = one * one * HUE_SECTOR_UNITS;
            h = longint'(item.hue);
            s = longint'(item.sat);
            v = longint'(item.val);
            if (s > one)
                s = one;
            if (v > one)
                v = one;
            // wrap hue past a full turn
            if (h >= HUE_FULL_UNITS)
                h = h - HUE_FULL_UNITS;
            pos = h % (2 * HUE_SECTOR_UNITS);
            ramp = (pos >= HUE_SECTOR_UNITS) ? pos - HUE_SECTOR_UNITS
                                              : HUE_SECTOR_UNITS - pos;
            chroma = v * s * HUE_SECTOR_UNITS;
            second = v * s * (HUE_SECTOR_UNITS - ramp);
            offset = v * one * HUE_SECTOR_UNITS - chroma;
            sector = SEC_W'(h / HUE_SECTOR_UNITS);
            case (sector)
                SEC_RED_YEL: begin rp = chroma; gp = second; bp = 0;      end
                SEC_YEL_GRN: begin rp = second; gp = chroma; bp = 0;      end
                SEC_GRN_CYN: begin rp = 0;      gp = chroma; bp = second; end
                SEC_CYN_BLU: begin rp = 0;      gp = second; bp = chroma; end
                SEC_BLU_MAG: begin rp = second; gp = 0;      bp = chroma; end
                default:     begin rp = chroma; gp = 0;      bp = second; end
            endcase
            rgb.red = scale_to_byte(rp + offset, denom);
            rgb.green = scale_to_byte(gp + offset, denom);
            rgb.blue = scale_to_byte(bp + offset, denom);
            return rgb;
        end
    endfunction

    task automatic report_mismatch(input string msg);
        begin
            if (mismatch_count < PRINT_CAP)
                $display("mismatch at %0t: %s", $time, msg);
            mismatch_count++;
        end
    endtask

    task automatic check_channel(input string chan, input logic [CH_W-1:0] got,
                                 input logic [CH_W-1:0] want);
        begin
            if (got !== want)
                report_mismatch($sformatf("%s got %0d expected %0d", chan, got, want));
        end
    endtask

    task automatic queue_color(input int h, input int s, input int v);
        hsv_item_t item;
        begin
            item.hue = IN_W'(h);
            item.sat = IN_W'(s);
            item.val = IN_W'(v);
            pending_colors.push_back(item);
        end
    endtask

    // Random fraction: mostly in range, with the ends and over-range codes mixed in
    function automatic int pick_fraction();
        begin
            case ($urandom_range(9))
                0: return 0;
                1: return ONE;
                2: return $urandom_range((1 << IN_W) - 1);
                3: return ONE - $urandom_range(3);
                default: return $urandom_range(ONE);
            endcase
        end
    endfunction

    // Random hue: mostly in range, some at sector edges, some over range
    function automatic int pick_hue();
        begin
            case ($urandom_range(9))
                0: return HUE_SECTOR_UNITS * $urandom_range(5)
                          + ($urandom_range(1) ? 0 : HUE_SECTOR_UNITS - 1);
                1: return $urandom_range((1 << IN_W) - 1);
                default: return $urandom_range(HUE_FULL_UNITS - 1);
            endcase
        end
    endfunction

    task automatic queue_random_colors(input int count);
        begin
            repeat (count)
                queue_color(pick_hue(), pick_fraction(), pick_fraction());
        end
    endtask

    task automatic wait_colors_sent();
        begin
            while (pending_colors.size() != 0 || in_valid)
                @(posedge clk);
        end
    endtask

    // Sender: offer the next item at the falling edge, hold it until taken
    always @(negedge clk)
    begin : drive_colors
        hsv_item_t nxt;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_taken)
        begin
            if (pending_colors.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = pending_colors.pop_front();
                hue <= nxt.hue;
                saturation <= nxt.sat;
                brightness_level <= nxt.val;
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: random ready, plus one long hold-off on request
    always @(negedge clk)
    begin : drive_ready
        int  hold_left;
        bit  hold_started;
        if (hold_off_req && !hold_started)
        begin
            hold_started = 1'b1;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Monitor: record accepted items, check accepted results against predictions
    always @(posedge clk)
    begin : watch_ports
        hsv_item_t taken;
        rgb_item_t want;
        in_taken <= rst_n && in_valid && in_ready;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_rgb.size() == 0)
                    report_mismatch($sformatf("unexpected result r=%0d g=%0d b=%0d",
                                              red, green, blue));
                else
                begin
                    want = expected_rgb.pop_front();
                    check_channel("red", red, want.red);
                    check_channel("green", green, want.green);
                    check_channel("blue", blue, want.blue);
                    colors_checked++;
                end
            end
            if (in_valid && !in_ready)
                stalled_input_cycles++;
            if (in_valid && in_ready)
            begin
                taken.hue = hue;
                taken.sat = saturation;
                taken.val = brightness_level;
                expected_rgb.push_back(convert_hsv(taken));
                colors_taken++;
            end
        end
    end

    // Stimulus and end of run
    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 33;
        recv_idle_pct = 48;
        // sector edges at full saturation and value
        queue_color(0, ONE, ONE);
        queue_color(959, ONE, ONE);
        queue_color(960, ONE, ONE);
        queue_color(1919, ONE, ONE);
        queue_color(1920, ONE, ONE);
        queue_color(2879, ONE, ONE);
        queue_color(2880, ONE, ONE);
        queue_color(3839, ONE, ONE);
        queue_color(3840, ONE, ONE);
        queue_color(4799, ONE, ONE);
        queue_color(4800, ONE, ONE);
        queue_color(5759, ONE, ONE);
        // hue wrap past a full turn, and the largest code
        queue_color(5760, ONE, ONE);
        queue_color((1 << IN_W) - 1, ONE, ONE);
        // gray and black
        queue_color(1234, 0, ONE);
        queue_color(3000, ONE, 0);
        queue_color(0, 0, 0);
        // over-range fractions saturate to one
        queue_color(3000, (1 << IN_W) - 1, (1 << IN_W) - 1);
        queue_color(480, ONE + 1, ONE + 1);
        // mid-sector and just under one
        queue_color(480, ONE / 2, ONE / 2);
        queue_color(1440, ONE - 1, ONE - 1);
        queue_color(4321, 1, 1);
        queue_color(7000, 2500, 3100);
        queue_random_colors(680);
        wait_colors_sent();

        send_idle_pct = 48;
        recv_idle_pct = 33;
        queue_random_colors(700);
        wait_colors_sent();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_colors(250);
        wait_colors_sent();

        // long receiver hold-off while the sender keeps offering
        hold_off_req = 1'b1;
        queue_random_colors(250);
        wait_colors_sent();

        while (expected_rgb.size() != 0)
            @(posedge clk);
        repeat (4 * PIPE_LATENCY) @(posedge clk);

        $display("converted %0d colors, checked %0d results, %0d mismatches",
                 colors_taken, colors_checked, mismatch_count);
        $display("input held back by the block on %0d cycles", stalled_input_cycles);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(RUN_LIMIT);
        $display("timeout with %0d results outstanding", expected_rgb.size());
        $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
